[rtl/vmd_pkg.sv]
// Shared types, constants and arctangent table of the vector magnitude and direction unit.
package vmd_pkg;

  localparam int unsigned ZACC_W      = 32;
  localparam int unsigned MAG_W       = 25;
  localparam int unsigned GUARD_SHIFT = 16;
  localparam int unsigned MAX_STEPS   = 24;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [ZACC_W-1:0] TURN_ZERO          = 32'h0000_0000;
  localparam logic [ZACC_W-1:0] TURN_QUARTER       = 32'h4000_0000;
  localparam logic [ZACC_W-1:0] TURN_HALF          = 32'h8000_0000;
  localparam logic [ZACC_W-1:0] TURN_THREE_QUARTER = 32'hC000_0000;

  localparam logic [MAG_W-1:0] MAG_MAX = '1;

  typedef enum logic [2:0] {
    VEC_ZERO,
    VEC_POS_X,
    VEC_NEG_X,
    VEC_UP,
    VEC_DOWN,
    VEC_GENERAL
  } vec_kind_e;

  localparam int unsigned KIND_W = 3;

  function automatic logic [ZACC_W-1:0] atan_unit(input int unsigned idx);
    logic [ZACC_W-1:0] a;
    case (idx)
      0:  a = 32'h2000_0000;
      1:  a = 32'h12E4_051E;
      2:  a = 32'h09FB_385B;
      3:  a = 32'h0511_11D4;
      4:  a = 32'h028B_0D43;
      5:  a = 32'h0145_D7E1;
      6:  a = 32'h00A2_F61E;
      7:  a = 32'h0051_7C55;
      8:  a = 32'h0028_BE53;
      9:  a = 32'h0014_5F2F;
      10: a = 32'h000A_2F98;
      11: a = 32'h0005_17CC;
      12: a = 32'h0002_8BE6;
      13: a = 32'h0001_45F3;
      14: a = 32'h0000_A2FA;
      15: a = 32'h0000_517D;
      16: a = 32'h0000_28BE;
      17: a = 32'h0000_145F;
      18: a = 32'h0000_0A30;
      19: a = 32'h0000_0518;
      20: a = 32'h0000_028C;
      21: a = 32'h0000_0146;
      22: a = 32'h0000_00A3;
      23: a = 32'h0000_0051;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

[rtl/vmd_front.sv]
// Front stage: accept a point pair, form the difference vector and classify it.
module vmd_front import vmd_pkg::*; #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [COORD_BITS-1:0] start_x_i,
  input  logic signed [COORD_BITS-1:0] start_y_i,
  input  logic signed [COORD_BITS-1:0] end_x_i,
  input  logic signed [COORD_BITS-1:0] end_y_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [COORD_BITS:0]   out_dx_o,
  output logic signed [COORD_BITS:0]   out_dy_o,
  output vec_kind_e                    out_kind_o
);

  localparam int unsigned C = COORD_BITS;

  logic              valid_d, valid_q;
  logic signed [C:0] dx_d, dx_q, dy_d, dy_q;
  vec_kind_e         kind_d, kind_q;
  logic              load;

  assign in_ready_o = !valid_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    dx_d = {end_x_i[C-1], end_x_i} - {start_x_i[C-1], start_x_i};
    dy_d = {end_y_i[C-1], end_y_i} - {start_y_i[C-1], start_y_i};
    if (dx_d == '0 && dy_d == '0) begin
      kind_d = VEC_ZERO;
    end else if (dy_d == '0) begin
      kind_d = dx_d[C] ? VEC_NEG_X : VEC_POS_X;
    end else if (dx_d == '0) begin
      kind_d = dy_d[C] ? VEC_UP : VEC_DOWN;
    end else begin
      kind_d = VEC_GENERAL;
    end
    valid_d = load || (valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      dx_q   <= dx_d;
      dy_q   <= dy_d;
      kind_q <= kind_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_dx_o    = dx_q;
  assign out_dy_o    = dy_q;
  assign out_kind_o  = kind_q;

endmodule

[rtl/vmd_queue.sv]
// Short register queue that decouples the front stage from the compute pipeline.
module vmd_queue import vmd_pkg::*; #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [WIDTH-1:0] in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [WIDTH-1:0] out_data_o
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_d, wr_ptr_q, rd_ptr_d, rd_ptr_q;
  logic [CNT_W-1:0] count_d, count_q;
  logic             push, pop;

  assign in_ready_o  = count_q != CNT_W'(QUEUE_DEPTH);
  assign out_valid_o = count_q != '0;
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;
  assign out_data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    case ({push, pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_data_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(QUEUE_DEPTH))
    else $error("queue fill count beyond depth");

endmodule

[rtl/vmd_back.sv]
// Compute pipeline: squares, digit-by-digit square root and CORDIC vectoring in lockstep.
module vmd_back import vmd_pkg::*; #(
  parameter int unsigned COORD_BITS     = 16,
  parameter int unsigned ANGLE_BITS     = 16,
  parameter int unsigned ROTATION_STEPS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [COORD_BITS:0] in_dx_i,
  input  logic signed [COORD_BITS:0] in_dy_i,
  input  vec_kind_e                  in_kind_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [MAG_W-1:0]           out_magnitude_o,
  output logic [ANGLE_BITS-1:0]      out_direction_o,
  output logic                       out_no_motion_o
);

  localparam int unsigned C      = COORD_BITS;
  localparam int unsigned SUM_W  = 2 * C + 1;
  localparam int unsigned RAD_W  = SUM_W + GUARD_SHIFT + 1;
  localparam int unsigned ROOT_W = RAD_W / 2;
  localparam int unsigned REM_W  = ROOT_W + 2;
  localparam int unsigned CX_W   = C + GUARD_SHIFT + 3;
  localparam int unsigned ROT    = ROTATION_STEPS > MAX_STEPS ? MAX_STEPS : ROTATION_STEPS;
  localparam int unsigned NSTG   = ROOT_W > ROT ? ROOT_W : ROT;
  localparam logic [ZACC_W-1:0] ROUND_HALF = ZACC_W'(1) << (ZACC_W - 1 - ANGLE_BITS);

  logic adv;

  // stage A: squares and CORDIC start vector
  logic                     a_vld_d, a_vld_q;
  vec_kind_e                a_kind_q;
  logic [2*C-1:0]           a_sqx_d, a_sqx_q, a_sqy_d, a_sqy_q;
  logic signed [CX_W-1:0]   a_x_d, a_x_q, a_y_d, a_y_q;
  logic [ZACC_W-1:0]        a_z_d, a_z_q;
  logic [C:0]               dx_abs, dy_abs;
  logic signed [C:0]        y_src;

  // stage B: radicand
  logic                     b_vld_d, b_vld_q;
  vec_kind_e                b_kind_q;
  logic [RAD_W-1:0]         b_rad_d, b_rad_q;
  logic signed [CX_W-1:0]   b_x_q, b_y_q;
  logic [ZACC_W-1:0]        b_z_q;

  // iteration stages
  logic [NSTG-1:0]          it_vld_d, it_vld_q;
  vec_kind_e                it_kind_q [NSTG];
  logic [RAD_W-1:0]         it_rad_d  [NSTG];
  logic [RAD_W-1:0]         it_rad_q  [NSTG];
  logic [REM_W-1:0]         it_rem_d  [NSTG];
  logic [REM_W-1:0]         it_rem_q  [NSTG];
  logic [ROOT_W-1:0]        it_root_d [NSTG];
  logic [ROOT_W-1:0]        it_root_q [NSTG];
  logic signed [CX_W-1:0]   it_x_d    [NSTG];
  logic signed [CX_W-1:0]   it_x_q    [NSTG];
  logic signed [CX_W-1:0]   it_y_d    [NSTG];
  logic signed [CX_W-1:0]   it_y_q    [NSTG];
  logic [ZACC_W-1:0]        it_z_d    [NSTG];
  logic [ZACC_W-1:0]        it_z_q    [NSTG];

  // output register
  logic                     out_valid_d, out_valid_q;
  logic [MAG_W-1:0]         mag_d, mag_q, mag_sat;
  logic [ANGLE_BITS-1:0]    dir_d, dir_q;
  logic                     nm_d, nm_q;
  logic [ZACC_W-1:0]        z_sel, z_rnd;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  always_comb begin
    dx_abs  = in_dx_i[C] ? ~in_dx_i + 1'b1 : in_dx_i;
    dy_abs  = in_dy_i[C] ? ~in_dy_i + 1'b1 : in_dy_i;
    a_sqx_d = dx_abs[C-1:0] * dx_abs[C-1:0];
    a_sqy_d = dy_abs[C-1:0] * dy_abs[C-1:0];
    // fold the left half plane onto the right one
    y_src   = in_dx_i[C] ? in_dy_i : ~in_dy_i + 1'b1;
    a_x_d   = {{(CX_W - C - GUARD_SHIFT){1'b0}}, dx_abs[C-1:0], {GUARD_SHIFT{1'b0}}};
    a_y_d   = {{(CX_W - C - 1 - GUARD_SHIFT){y_src[C]}}, y_src, {GUARD_SHIFT{1'b0}}};
    a_z_d   = in_dx_i[C] ? TURN_HALF : TURN_ZERO;
    a_vld_d = adv ? in_valid_i : a_vld_q;
    b_vld_d = adv ? a_vld_q : b_vld_q;
    b_rad_d = {1'b0, SUM_W'(a_sqx_q) + SUM_W'(a_sqy_q), {GUARD_SHIFT{1'b0}}};
  end

  for (genvar k = 0; k < NSTG; k++) begin : g_stage
    logic                   vld_in;
    vec_kind_e              kind_in;
    logic [RAD_W-1:0]       rad_in;
    logic [REM_W-1:0]       rem_in, rem_sh, trial;
    logic [ROOT_W-1:0]      root_in;
    logic signed [CX_W-1:0] x_in, y_in;
    logic [ZACC_W-1:0]      z_in;

    if (k == 0) begin : g_first
      assign vld_in  = b_vld_q;
      assign kind_in = b_kind_q;
      assign rad_in  = b_rad_q;
      assign rem_in  = '0;
      assign root_in = '0;
      assign x_in    = b_x_q;
      assign y_in    = b_y_q;
      assign z_in    = b_z_q;
    end else begin : g_next
      assign vld_in  = it_vld_q[k-1];
      assign kind_in = it_kind_q[k-1];
      assign rad_in  = it_rad_q[k-1];
      assign rem_in  = it_rem_q[k-1];
      assign root_in = it_root_q[k-1];
      assign x_in    = it_x_q[k-1];
      assign y_in    = it_y_q[k-1];
      assign z_in    = it_z_q[k-1];
    end

    assign rem_sh = {rem_in[ROOT_W-1:0], rad_in[RAD_W-1 -: 2]};
    assign trial  = {root_in, 2'b01};

    always_comb begin
      it_vld_d[k] = adv ? vld_in : it_vld_q[k];
      if (k < ROOT_W) begin
        it_rad_d[k] = rad_in << 2;
        if (rem_sh >= trial) begin
          it_rem_d[k]  = rem_sh - trial;
          it_root_d[k] = {root_in[ROOT_W-2:0], 1'b1};
        end else begin
          it_rem_d[k]  = rem_sh;
          it_root_d[k] = {root_in[ROOT_W-2:0], 1'b0};
        end
      end else begin
        it_rad_d[k]  = rad_in;
        it_rem_d[k]  = rem_in;
        it_root_d[k] = root_in;
      end
      if (k < ROT) begin
        if (!y_in[CX_W-1]) begin
          it_x_d[k] = x_in + (y_in >>> k);
          it_y_d[k] = y_in - (x_in >>> k);
          it_z_d[k] = z_in + atan_unit(k);
        end else begin
          it_x_d[k] = x_in - (y_in >>> k);
          it_y_d[k] = y_in + (x_in >>> k);
          it_z_d[k] = z_in - atan_unit(k);
        end
      end else begin
        it_x_d[k] = x_in;
        it_y_d[k] = y_in;
        it_z_d[k] = z_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        it_kind_q[k] <= kind_in;
        it_rad_q[k]  <= it_rad_d[k];
        it_rem_q[k]  <= it_rem_d[k];
        it_root_q[k] <= it_root_d[k];
        it_x_q[k]    <= it_x_d[k];
        it_y_q[k]    <= it_y_d[k];
        it_z_q[k]    <= it_z_d[k];
      end
    end
  end

  if (ROOT_W > MAG_W) begin : g_sat
    assign mag_sat = (|it_root_q[NSTG-1][ROOT_W-1:MAG_W]) ? MAG_MAX :
                     it_root_q[NSTG-1][MAG_W-1:0];
  end else begin : g_nosat
    assign mag_sat = MAG_W'(it_root_q[NSTG-1]);
  end

  always_comb begin
    case (it_kind_q[NSTG-1])
      VEC_ZERO:    z_sel = TURN_ZERO;
      VEC_POS_X:   z_sel = TURN_ZERO;
      VEC_NEG_X:   z_sel = TURN_HALF;
      VEC_UP:      z_sel = TURN_QUARTER;
      VEC_DOWN:    z_sel = TURN_THREE_QUARTER;
      VEC_GENERAL: z_sel = it_z_q[NSTG-1];
      default:     z_sel = it_z_q[NSTG-1];
    endcase
    z_rnd       = z_sel + ROUND_HALF;
    nm_d        = it_kind_q[NSTG-1] == VEC_ZERO;
    mag_d       = nm_d ? '0 : mag_sat;
    dir_d       = z_rnd[ZACC_W-1 -: ANGLE_BITS];
    out_valid_d = adv ? it_vld_q[NSTG-1] : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q     <= 1'b0;
      b_vld_q     <= 1'b0;
      it_vld_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      a_vld_q     <= a_vld_d;
      b_vld_q     <= b_vld_d;
      it_vld_q    <= it_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_kind_q <= in_kind_i;
      a_sqx_q  <= a_sqx_d;
      a_sqy_q  <= a_sqy_d;
      a_x_q    <= a_x_d;
      a_y_q    <= a_y_d;
      a_z_q    <= a_z_d;
      b_kind_q <= a_kind_q;
      b_rad_q  <= b_rad_d;
      b_x_q    <= a_x_q;
      b_y_q    <= a_y_q;
      b_z_q    <= a_z_q;
      mag_q    <= mag_d;
      dir_q    <= dir_d;
      nm_q     <= nm_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_magnitude_o = mag_q;
  assign out_direction_o = dir_q;
  assign out_no_motion_o = nm_q;

  a_zero_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && nm_q |-> mag_q == '0 && dir_q == '0)
    else $error("no-motion word with nonzero magnitude or direction");

  a_nonzero_mag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !nm_q |-> mag_q != '0)
    else $error("moving vector with zero magnitude");

  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(it_vld_q) && $stable(a_vld_q) && $stable(b_vld_q))
    else $error("pipeline moved while output stalled");

endmodule

[rtl/vector_magnitude_and_direction_unit.sv]
// Top level of the vector magnitude and direction unit.
//
// Slave channel s_axis_*: one word per point pair (start_x, start_y, end_x, end_y).
// Master channel m_axis_*: one word per accepted input word, in order: length of
// the difference vector (8 fraction bits, saturating) and its direction as a
// binary angle, atan2(-dy, dx) with y growing downward; m_axis_tuser flags a
// zero vector, whose direction then reads 0.
// Throughput: one word per cycle while m_axis_tready does not stall the output. The
// longer of the square root chain, one root bit per stage, and the CORDIC
// rotations sets the number of iteration stages; the CORDIC rotations run
// beside the root steps in the same stages.
// A front register and a four-word queue decouple input acceptance from the
// compute pipeline; a stall on m_axis_tready freezes the pipeline while the
// front keeps taking words until the queue is full.
// Reset empties the queue and all stages; no word is in flight afterwards.
module vector_magnitude_and_direction_unit import vmd_pkg::*; #(
  parameter int unsigned COORD_BITS     = 16,
  parameter int unsigned ANGLE_BITS     = 16,
  parameter int unsigned ROTATION_STEPS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // start_x, start_y, end_x, end_y, zero padding
  input  logic [((4 * COORD_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // magnitude, direction, zero padding
  output logic [((MAG_W + ANGLE_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
  // no_motion
  output logic                  m_axis_tuser
);

  localparam int unsigned C     = COORD_BITS;
  localparam int unsigned OUT_W = ((MAG_W + ANGLE_BITS + 7) / 8) * 8;
  localparam int unsigned Q_W   = KIND_W + 2 * (C + 1);

  logic                  f_valid, f_ready;
  logic signed [C:0]     f_dx, f_dy;
  vec_kind_e             f_kind;
  logic                  q_valid, q_ready;
  logic [Q_W-1:0]        q_in, q_out;
  logic [MAG_W-1:0]      magnitude;
  logic [ANGLE_BITS-1:0] direction;

  vmd_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .start_x_i   (s_axis_tdata[C-1:0]),
    .start_y_i   (s_axis_tdata[2*C-1:C]),
    .end_x_i     (s_axis_tdata[3*C-1:2*C]),
    .end_y_i     (s_axis_tdata[4*C-1:3*C]),
    .out_valid_o (f_valid),
    .out_ready_i (f_ready),
    .out_dx_o    (f_dx),
    .out_dy_o    (f_dy),
    .out_kind_o  (f_kind)
  );

  assign q_in = {f_kind, f_dx, f_dy};

  vmd_queue #(
    .WIDTH (Q_W)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (f_valid),
    .in_ready_o  (f_ready),
    .in_data_i   (q_in),
    .out_valid_o (q_valid),
    .out_ready_i (q_ready),
    .out_data_o  (q_out)
  );

  vmd_back #(
    .COORD_BITS     (COORD_BITS),
    .ANGLE_BITS     (ANGLE_BITS),
    .ROTATION_STEPS (ROTATION_STEPS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (q_valid),
    .in_ready_o      (q_ready),
    .in_dx_i         (q_out[2*(C+1)-1:C+1]),
    .in_dy_i         (q_out[C:0]),
    .in_kind_i       (vec_kind_e'(q_out[Q_W-1 -: KIND_W])),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .out_magnitude_o (magnitude),
    .out_direction_o (direction),
    .out_no_motion_o (m_axis_tuser)
  );

  assign m_axis_tdata = OUT_W'({direction, magnitude});

endmodule
